### design/trrs_pkg.sv
`default_nettype none
package trrs_pkg;
	localparam int Depth = 1024;
	localparam int SlotW = $clog2(Depth);
	localparam int CntW = SlotW + 1;
	localparam int TimeW = 63;
	localparam int ValW = 32;
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_RANGE = 2'd1,
		KIND_CHUNK = 2'd2,
		KIND_READ = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [TimeW-1:0] t0;
		logic [TimeW-1:0] t1;
		logic [ValW-1:0] val;
		logic plot;
		logic [SlotW-1:0] rslot;
	} item_t;

	typedef struct packed {
		logic found;
		logic [SlotW-1:0] start;
		logic [CntW-1:0] len;
		logic [TimeW-1:0] etime;
		logic [ValW-1:0] evalue;
		logic eplot;
	} result_t;
endpackage
`default_nettype wire

### design/trrs_front.sv
`default_nettype none
// A short queue of items toward the search engine.
module trrs_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire trrs_pkg::item_t in_item,
	output logic q_valid,
	input wire logic q_pop,
	output trrs_pkg::item_t q_item
);
	import trrs_pkg::*;
	localparam int PtrW = $clog2(QDepth);
	item_t mem_q [QDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == (PtrW+1)'(QDepth));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end
endmodule
`default_nettype wire

### design/trrs_back.sv
`default_nettype none
// Sequencer that executes one item at a time against the ring memory.
module trrs_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [10:0] cfg_data,
	input wire logic q_valid,
	output logic q_pop,
	input wire trrs_pkg::item_t q_item,
	output logic out_valid,
	input wire logic out_stall,
	output trrs_pkg::result_t out_res
);
	import trrs_pkg::*;
	typedef enum logic [2:0] {
		IDLE, PROBE, WAIT, CHECK, FINISH, RDWAIT, OUTPUT
	} state_t;

	state_t state_q;
	logic [TimeW-1:0] tmem [Depth];
	logic [ValW-1:0] vmem [Depth];
	logic pmem [Depth];

	logic [CntW-1:0] len_q, fill_q;
	logic [SlotW-1:0] wslot_q, first_q, last_q;
	item_t it_q;
	result_t res_q;
	logic [CntW-1:0] lo_q, hi_q, pf_q, mid_q;
	logic pass_q;
	logic [TimeW-1:0] rd_t_q;
	logic [ValW-1:0] rd_v_q;
	logic rd_p_q;
	logic [SlotW-1:0] raddr;
	logic rd_en;

	function automatic logic [CntW-1:0] clamp(input logic [10:0] v);
		logic [CntW-1:0] r;
		if (v < 11'd2) r = CntW'(2);
		else if ({1'b0, v} > 12'(Depth)) r = CntW'(Depth);
		else r = CntW'(v);
		return r;
	endfunction

	// Physical slot of logical position p: (wslot + 1 - fill + p) mod len.
	function automatic logic [SlotW-1:0] slot_of(input logic [CntW-1:0] p,
		input logic [SlotW-1:0] ws, input logic [CntW-1:0] f,
		input logic [CntW-1:0] l);
		logic [CntW+1:0] s;
		s = (CntW+2)'(ws) + (CntW+2)'(l) + (CntW+2)'(1) - (CntW+2)'(f);
		if (s >= (CntW+2)'(l)) s = s - (CntW+2)'(l);
		s = s + (CntW+2)'(p);
		if (s >= (CntW+2)'(l)) s = s - (CntW+2)'(l);
		return s[SlotW-1:0];
	endfunction

	logic [CntW-1:0] mid_c;
	logic [SlotW-1:0] nws;
	logic [SlotW-1:0] rf, rl;
	logic [CntW-1:0] span;
	logic [TimeW-1:0] key;
	logic go_right;
	result_t res_init;

	assign mid_c = lo_q + ((hi_q - lo_q) >> 1);
	assign nws = ({1'b0, wslot_q} + 1'b1 >= len_q) ? '0 : wslot_q + 1'b1;
	assign cfg_ready = (state_q == IDLE) && !q_valid;
	assign q_pop = (state_q == IDLE) && q_valid;
	assign out_valid = (state_q == OUTPUT);
	assign out_res = res_q;
	assign key = pass_q ? it_q.t1 : it_q.t0;
	assign go_right = pass_q ? (rd_t_q <= key) : (rd_t_q < key);
	assign rd_en = (state_q == PROBE) || (state_q == IDLE && q_valid);
	assign raddr = (state_q == PROBE) ? slot_of(mid_c, wslot_q, fill_q, len_q)
		: q_item.rslot;

	// Result fields known as soon as the item leaves the queue.
	always_comb begin
		res_init = '0;
		if (q_item.kind == KIND_RANGE || q_item.kind == KIND_CHUNK)
			res_init.start = first_q;
		if (q_item.kind == KIND_CHUNK) begin
			if (first_q < last_q)
				res_init.len = CntW'(last_q) - CntW'(first_q) + 1'b1;
			else if (first_q > last_q)
				res_init.len = len_q - CntW'(first_q);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_t_q <= tmem[raddr];
			rd_v_q <= vmem[raddr];
			rd_p_q <= pmem[raddr];
		end
		if (state_q == IDLE && q_valid && q_item.kind == KIND_SAMPLE) begin
			tmem[nws] <= q_item.t0;
			pmem[nws] <= q_item.plot;
			if (q_item.plot) vmem[nws] <= q_item.val;
		end
	end

	always_comb begin
		rf = slot_of(pf_q, wslot_q, fill_q, len_q);
		rl = slot_of(lo_q - 1'b1, wslot_q, fill_q, len_q);
		if (!(pf_q < fill_q && lo_q != '0 && pf_q <= lo_q - 1'b1)) rf = last_q;
		if (!(pf_q < fill_q && lo_q != '0 && pf_q <= lo_q - 1'b1)) rl = last_q;
		if (rf == rl) span = '0;
		else if (rf < rl) span = CntW'(rl) - CntW'(rf) + 1'b1;
		else span = len_q - CntW'(rf) + CntW'(rl) + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			len_q <= clamp(11'd1024);
			fill_q <= '0;
			wslot_q <= '0;
			first_q <= '0;
			last_q <= '0;
			pass_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (cfg_valid && cfg_ready) begin
						len_q <= clamp(cfg_data);
						fill_q <= '0;
						wslot_q <= '0;
						first_q <= '0;
						last_q <= '0;
					end else if (q_valid) begin
						it_q <= q_item;
						res_q <= res_init;
						unique case (q_item.kind)
							KIND_SAMPLE: begin
								wslot_q <= nws;
								if (fill_q < len_q) fill_q <= fill_q + 1'b1;
								state_q <= OUTPUT;
							end
							KIND_RANGE: begin
								lo_q <= '0;
								hi_q <= fill_q;
								pass_q <= 1'b0;
								state_q <= PROBE;
							end
							KIND_CHUNK: begin
								if (first_q < last_q) first_q <= last_q;
								else if (first_q > last_q) first_q <= '0;
								state_q <= OUTPUT;
							end
							default: begin
								state_q <= RDWAIT;
							end
						endcase
					end
				end
				PROBE: begin
					if (lo_q < hi_q) begin
						mid_q <= mid_c;
						state_q <= WAIT;
					end else if (!pass_q) begin
						pf_q <= lo_q;
						pass_q <= 1'b1;
						lo_q <= '0;
						hi_q <= fill_q;
					end else begin
						state_q <= FINISH;
					end
				end
				WAIT: state_q <= CHECK;
				CHECK: begin
					if (go_right) lo_q <= mid_q + 1'b1;
					else hi_q <= mid_q;
					state_q <= PROBE;
				end
				FINISH: begin
					first_q <= rf;
					last_q <= rl;
					res_q.start <= rf;
					res_q.len <= span;
					res_q.found <= (span != '0);
					state_q <= OUTPUT;
				end
				RDWAIT: begin
					res_q.etime <= rd_t_q;
					res_q.evalue <= rd_v_q;
					res_q.eplot <= rd_p_q;
					state_q <= OUTPUT;
				end
				OUTPUT: if (!out_stall) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/timestamped_ring_range_search.sv
`default_nettype none
// Channel | Direction | Handshake       | Beat
// in      | in        | in_valid/stall  | kind, times, value, plotable, read_slot
// out     | out       | out_valid/stall | found, start, length, entry fields
// cfg     | in        | cfg_valid/ready | ring_length
// Samples and chunk takes go from the queue straight to the output state,
// reads pass through RDWAIT first; a range query runs two binary searches
// of up to 11 probes, each stepping PROBE, WAIT and CHECK around the single
// ring read port, and then FINISH before its result goes out.
// Reset is asynchronous; the ring contents are not cleared, only the pointers.
// A two-entry queue accepts items while a result waits on out_stall.
module timestamped_ring_range_search (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [10:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] kind,
	input wire logic [62:0] stamp_time,
	input wire logic [62:0] end_time,
	input wire logic signed [31:0] sample_value,
	input wire logic sample_plotable,
	input wire logic [9:0] read_slot,
	output logic out_valid,
	input wire logic out_stall,
	output logic range_found,
	output logic [9:0] start_slot,
	output logic [10:0] run_length,
	output logic [62:0] entry_time,
	output logic signed [31:0] entry_value,
	output logic entry_plotable
);
	import trrs_pkg::*;
	item_t in_item, q_item;
	result_t res;
	logic q_valid, q_pop;

	assign in_item.kind = kind_t'(kind);
	assign in_item.t0 = stamp_time;
	assign in_item.t1 = end_time;
	assign in_item.val = sample_value;
	assign in_item.plot = sample_plotable;
	assign in_item.rslot = read_slot;

	trrs_front u_front (.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.q_valid, .q_pop, .q_item);
	trrs_back u_back (.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_data,
		.q_valid, .q_pop, .q_item, .out_valid, .out_stall, .out_res(res));

	assign range_found = res.found;
	assign start_slot = res.start;
	assign run_length = res.len;
	assign entry_time = res.etime;
	assign entry_value = res.evalue;
	assign entry_plotable = res.eplot;
endmodule
`default_nettype wire

### design/trrs_checker.sv
`default_nettype none
module trrs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic range_found,
	input wire logic [10:0] run_length,
	input wire logic cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_found |-> run_length != 11'd0) else $error("empty span found");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !out_valid) else $error("config while busy");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length <= 11'd1024) else $error("length too big");
endmodule
bind timestamped_ring_range_search trrs_checker u_chk (.clk, .arst_n, .out_valid,
	.out_stall, .range_found, .run_length, .cfg_ready);
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import trrs_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [10:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] kind;
	logic [62:0] stamp_time;
	logic [62:0] end_time;
	logic signed [31:0] sample_value;
	logic sample_plotable;
	logic [9:0] read_slot;
	logic out_valid;
	logic out_stall;
	logic range_found;
	logic [9:0] start_slot;
	logic [10:0] run_length;
	logic [62:0] entry_time;
	logic signed [31:0] entry_value;
	logic entry_plotable;

	timestamped_ring_range_search uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.stamp_time(stamp_time),
		.end_time(end_time),
		.sample_value(sample_value),
		.sample_plotable(sample_plotable),
		.read_slot(read_slot),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.range_found(range_found),
		.start_slot(start_slot),
		.run_length(run_length),
		.entry_time(entry_time),
		.entry_value(entry_value),
		.entry_plotable(entry_plotable)
	);

	// Shadow copy of the ring.
	logic [62:0] ring_times [Depth];
	logic [31:0] ring_values [Depth];
	logic ring_marks [Depth];
	logic value_known [Depth];
	int unsigned ring_len;
	int unsigned wr_slot;
	int unsigned filled;
	int unsigned span_first;
	int unsigned span_last;

	result_t expected_results [$];
	int idle_pct;
	int stall_pct;
	int errors;
	int items_sent;
	int results_seen;
	int configs_done;
	logic [62:0] cur_t;
	logic [62:0] base_t;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int unsigned slot_at(int unsigned p);
		int unsigned oldest;
		oldest = (wr_slot + ring_len + 1 - filled) % ring_len;
		return (oldest + p) % ring_len;
	endfunction

	// First age position with time >= t (strict: > t).
	function automatic int unsigned first_pos(logic [62:0] t, bit strict);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		logic [62:0] v;
		lo = 0;
		hi = filled;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			v = ring_times[slot_at(mid)];
			if (strict ? (v <= t) : (v < t))
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic void clear_ring(int unsigned len);
		ring_len = (len < 2) ? 2 : ((len > Depth) ? Depth : len);
		for (int i = 0; i < Depth; i++) begin
			ring_times[i] = '0;
			ring_values[i] = '0;
			ring_marks[i] = 1'b0;
			value_known[i] = 1'b0;
		end
		wr_slot = 0;
		filled = 0;
		span_first = 0;
		span_last = 0;
	endfunction

	function automatic result_t ring_predict(kind_t k, logic [62:0] t0, logic [62:0] t1,
			logic [31:0] v, logic p, logic [9:0] rs);
		result_t r;
		int unsigned pf;
		int unsigned pa;
		int unsigned span;
		bit ok;
		r = '0;
		case (k)
			KIND_SAMPLE: begin
				wr_slot = (wr_slot + 1) % ring_len;
				ring_times[wr_slot] = t0;
				ring_marks[wr_slot] = p;
				if (p) begin
					ring_values[wr_slot] = v;
					value_known[wr_slot] = 1'b1;
				end
				if (filled < ring_len)
					filled++;
			end
			KIND_RANGE: begin
				ok = 0;
				if (filled > 0) begin
					pf = first_pos(t0, 0);
					pa = first_pos(t1, 1);
					if (pf < filled && pa > 0 && pf <= pa - 1) begin
						span_first = slot_at(pf);
						span_last = slot_at(pa - 1);
						ok = 1;
					end
				end
				if (!ok)
					span_first = span_last;
				if (span_first == span_last)
					span = 0;
				else if (span_first < span_last)
					span = span_last - span_first + 1;
				else
					span = ring_len - span_first + span_last + 1;
				r.found = (span != 0);
				r.start = 10'(span_first);
				r.len = 11'(span);
			end
			KIND_CHUNK: begin
				r.start = 10'(span_first);
				if (span_first < span_last) begin
					r.len = 11'(span_last - span_first + 1);
					span_first = span_last;
				end else if (span_first > span_last) begin
					r.len = 11'(ring_len - span_first);
					span_first = 0;
				end
			end
			default: begin
				r.etime = ring_times[rs];
				r.evalue = ring_values[rs];
				r.eplot = ring_marks[rs];
			end
		endcase
		return r;
	endfunction

	task automatic send_item(kind_t k, logic [62:0] t0, logic [62:0] t1, logic [31:0] v,
			logic p, logic [9:0] rs);
		if ($urandom_range(99) < idle_pct)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		in_valid = 1'b1;
		kind = k;
		stamp_time = t0;
		end_time = t1;
		sample_value = v;
		sample_plotable = p;
		read_slot = rs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(ring_predict(k, t0, t1, v, p, rs));
		items_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_length(logic [10:0] len);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data = len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		clear_ring(len);
		configs_done++;
		@(negedge clk);
		cfg_valid = 1'b0;
		base_t = 63'({$urandom, $urandom} >> 3);
		cur_t = base_t;
	endtask

	function automatic logic [62:0] rand_t();
		return 63'({$urandom, $urandom});
	endfunction

	// Time near the filled window, occasionally anywhere.
	function automatic logic [62:0] near_t();
		logic [62:0] width;
		if ($urandom_range(9) == 0)
			return rand_t();
		width = cur_t - base_t + 8;
		return base_t + (rand_t() % width) - 4;
	endfunction

	task automatic rand_item();
		int r;
		int unsigned s;
		bit got;
		r = $urandom_range(99);
		if (r < 55) begin
			if ($urandom_range(19) == 0)
				send_item(KIND_SAMPLE, rand_t(), rand_t(), $urandom, 1'($urandom_range(1)),
					10'($urandom));
			else begin
				cur_t = cur_t + $urandom_range(0, 3);
				send_item(KIND_SAMPLE, cur_t, rand_t(), $urandom, $urandom_range(3) != 0,
					10'($urandom));
			end
		end else if (r < 75)
			send_item(KIND_RANGE, near_t(), near_t(), $urandom, 1'($urandom_range(1)),
				10'($urandom));
		else if (r < 88)
			send_item(KIND_CHUNK, rand_t(), rand_t(), $urandom, 1'($urandom_range(1)),
				10'($urandom));
		else begin
			got = 0;
			s = 0;
			for (int i = 0; i < 20 && !got; i++) begin
				s = $urandom_range(ring_len - 1);
				got = value_known[s];
			end
			if (got)
				send_item(KIND_READ, rand_t(), rand_t(), $urandom, 1'($urandom_range(1)),
					10'(s));
			else
				send_item(KIND_CHUNK, rand_t(), rand_t(), $urandom, 1'b0, 10'($urandom));
		end
	endtask

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t mismatch %s: expected %h, actual %h", $realtime, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result beat, start_slot %h run_length %h",
					$realtime, start_slot, run_length);
			end else begin
				e = expected_results.pop_front();
				check_field("range_found", e.found, range_found);
				check_field("start_slot", e.start, start_slot);
				check_field("run_length", e.len, run_length);
				check_field("entry_time", e.etime, entry_time);
				check_field("entry_value", e.evalue, $unsigned(entry_value));
				check_field("entry_plotable", e.eplot, entry_plotable);
			end
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	task automatic test_directed();
		logic [62:0] tmax;
		tmax = '1;
		idle_pct = 0;
		stall_pct = 0;
		// Empty ring and chunk with nothing pending.
		send_item(KIND_RANGE, 0, tmax, 0, 0, 0);
		send_item(KIND_CHUNK, 0, 0, 0, 0, 0);
		send_item(KIND_SAMPLE, 0, 0, 32'h8000_0000, 1, 0);
		// A lone sample: the span collapses onto one slot and is reported as not found.
		send_item(KIND_RANGE, 0, tmax, 0, 0, 0);
		send_item(KIND_SAMPLE, 100, 0, 32'h7fff_ffff, 1, 0);
		send_item(KIND_SAMPLE, 200, 0, 32'hffff_ffff, 0, 0);
		send_item(KIND_SAMPLE, tmax, tmax, 32'h1234_5678, 1, 0);
		send_item(KIND_RANGE, 50, 250, 0, 0, 0);
		send_item(KIND_CHUNK, 0, 0, 0, 0, 0);
		send_item(KIND_CHUNK, 0, 0, 0, 0, 0);
		send_item(KIND_RANGE, 300, 100, 0, 0, 0);
		send_item(KIND_RANGE, 150, 160, 0, 0, 0);
		send_item(KIND_RANGE, 0, tmax, 0, 0, 0);
		send_item(KIND_RANGE, tmax, tmax, 0, 0, 0);
		send_item(KIND_READ, 0, 0, 0, 0, 1);
		send_item(KIND_READ, 0, 0, 0, 0, 2);
		send_item(KIND_READ, tmax, tmax, 0, 0, 4);
	endtask

	task automatic test_length_extremes();
		// Lengths below the minimum and above the maximum get clamped.
		write_length(11'd0);
		repeat (12) rand_item();
		write_length(11'd1);
		repeat (12) rand_item();
		write_length(11'd2);
		repeat (20) rand_item();
		write_length(11'h7ff);
		stall_pct = 20;
		for (int i = 0; i < 300; i++) begin
			cur_t = cur_t + $urandom_range(1, 2);
			send_item(KIND_SAMPLE, cur_t, 0, $urandom, 1'b1, 0);
		end
		send_item(KIND_READ, 0, 0, 0, 0, 10'd1);
		send_item(KIND_READ, 0, 0, 0, 0, 10'd300);
		send_item(KIND_RANGE, base_t, cur_t, 0, 0, 0);
		repeat (3) send_item(KIND_CHUNK, 0, 0, 0, 0, 0);
		write_length(11'd1024);
		repeat (30) rand_item();
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 45; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 45; end
				default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			for (int c = 0; c < 2; c++) begin
				write_length((ph + c) % 3 == 0 ? 11'd1024 : 11'($urandom_range(2, 40)));
				repeat (75) rand_item();
			end
		end
	endtask

	task automatic test_pressure_pause();
		idle_pct = 11;
		stall_pct = 45;
		write_length(11'd7);
		repeat (30) rand_item();
		// Let every pending result come back before resuming.
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (30) rand_item();
	endtask

	initial begin
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		configs_done = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_SAMPLE;
		stamp_time = '0;
		end_time = '0;
		sample_value = '0;
		sample_plotable = 1'b0;
		read_slot = '0;
		clear_ring(Depth);
		base_t = 0;
		cur_t = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		test_length_extremes();
		test_random_traffic();
		test_pressure_pause();
		stall_pct = 0;
		wait_drained();
		$display("Covered %0d items and %0d result beats over %0d ring lengths,",
			items_sent, results_seen, configs_done);
		$display("with sender gaps and receiver stalls in separate and mixed phases.");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#8000000;
		$display("Timed out with %0d results outstanding", expected_results.size());
		$display("CHECK FAILED");
		$finish;
	end
endmodule

### filelist.f
design/trrs_pkg.sv
design/trrs_front.sv
design/trrs_back.sv
design/timestamped_ring_range_search.sv
design/trrs_checker.sv
tb/testbench.sv
